/* src/tps_pkg.sv */
// Package for the triangle plane slicer: widths, codes, records and helpers.
// No dependencies; every other file refers to it by scoped names.
package tps_pkg;

    localparam int CoordW = 32;
    localparam int NormW  = 16;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = DiffW + NormW;
    localparam int DistW  = ProdW + 2;
    localparam int DivW   = DistW + 1;
    localparam int QuoW   = 16;
    localparam int ParW   = QuoW + 1;
    localparam int LerpW  = ParW + 1 + DiffW;
    localparam int IdxW   = 3;

    localparam logic [ParW-1:0] PARAM_ONE = ParW'(1) << QuoW;

    typedef enum logic [1:0] {
        REL_ABOVE = 2'd0,
        REL_BELOW = 2'd1,
        REL_CROSS = 2'd2
    } rel_t;

    localparam logic [IdxW-1:0] CFG_POINT_X  = 3'd0;
    localparam logic [IdxW-1:0] CFG_POINT_Y  = 3'd1;
    localparam logic [IdxW-1:0] CFG_POINT_Z  = 3'd2;
    localparam logic [IdxW-1:0] CFG_NORMAL_X = 3'd3;
    localparam logic [IdxW-1:0] CFG_NORMAL_Y = 3'd4;
    localparam logic [IdxW-1:0] CFG_NORMAL_Z = 3'd5;

    // One lane of the restoring divider
    typedef struct packed {
        logic            sat;
        logic [DivW-1:0] den;
        logic [DivW-1:0] rem;
        logic [QuoW-1:0] quo;
    } div_t;

    // Geometry that rides alongside the divider
    typedef struct packed {
        rel_t                    rel;
        logic [1:0]              lone;
        logic [2:0][CoordW-1:0]  s1;
        logic [2:0][CoordW-1:0]  s2;
        logic [2:0][DiffW-1:0]   e1;
        logic [2:0][DiffW-1:0]   e2;
    } geo_t;

    // Zero shares a side with everything
    function automatic logic same_side(input logic signed [DistW-1:0] d1,
                                       input logic signed [DistW-1:0] d2);
        logic pos1, neg1, pos2, neg2;
        pos1 = !d1[DistW-1] && (d1 != '0);
        neg1 = d1[DistW-1];
        pos2 = !d2[DistW-1] && (d2 != '0);
        neg2 = d2[DistW-1];
        return !((pos1 && neg2) || (neg1 && pos2));
    endfunction

    // Set up the quotient -ds / (dl - ds) for the divider
    function automatic div_t param_prep(input logic signed [DistW-1:0] ds,
                                        input logic signed [DistW-1:0] dl);
        logic signed [DivW-1:0] a;
        logic signed [DivW-1:0] b;
        logic [DivW-1:0]        num;
        logic [DivW-1:0]        den;
        div_t                   res;
        a   = -DivW'(ds);
        b   = DivW'(dl) - DivW'(ds);
        num = a[DivW-1] ? DivW'(-a) : DivW'(a);
        den = b[DivW-1] ? DivW'(-b) : DivW'(b);
        res.quo = '0;
        if ((a == '0) || (b == '0) || (a[DivW-1] != b[DivW-1])) begin
            res.sat = 1'b0;
            res.den = DivW'(1);
            res.rem = '0;
        end else if (num >= den) begin
            res.sat = 1'b1;
            res.den = DivW'(1);
            res.rem = '0;
        end else begin
            res.sat = 1'b0;
            res.den = den;
            res.rem = num;
        end
        return res;
    endfunction

    // Round the quotient to nearest, halves up
    function automatic logic [ParW-1:0] param_final(input div_t d);
        logic up;
        up = {d.rem, 1'b0} >= {1'b0, d.den};
        if (d.sat) begin
            return PARAM_ONE;
        end
        return {1'b0, d.quo} + ParW'(up);
    endfunction

endpackage

/* src/tps_if.sv */
// Channel interfaces for the triangle plane slicer: triangles, segments, config.
// Depends on tps_pkg for widths.
interface tps_tri_if;
    logic                                valid;
    logic                                ready;
    logic signed [tps_pkg::CoordW-1:0]   vertex_a_x;
    logic signed [tps_pkg::CoordW-1:0]   vertex_a_y;
    logic signed [tps_pkg::CoordW-1:0]   vertex_a_z;
    logic signed [tps_pkg::CoordW-1:0]   vertex_b_x;
    logic signed [tps_pkg::CoordW-1:0]   vertex_b_y;
    logic signed [tps_pkg::CoordW-1:0]   vertex_b_z;
    logic signed [tps_pkg::CoordW-1:0]   vertex_c_x;
    logic signed [tps_pkg::CoordW-1:0]   vertex_c_y;
    logic signed [tps_pkg::CoordW-1:0]   vertex_c_z;

    modport source (output valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                    vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                    input ready);
    modport sink (input valid, vertex_a_x, vertex_a_y, vertex_a_z, vertex_b_x,
                  vertex_b_y, vertex_b_z, vertex_c_x, vertex_c_y, vertex_c_z,
                  output ready);
endinterface

interface tps_seg_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          relation;
    logic [1:0]                          lone_vertex;
    logic [tps_pkg::ParW-1:0]            tail_param;
    logic [tps_pkg::ParW-1:0]            head_param;
    logic signed [tps_pkg::CoordW-1:0]   seg_tail_x;
    logic signed [tps_pkg::CoordW-1:0]   seg_tail_y;
    logic signed [tps_pkg::CoordW-1:0]   seg_tail_z;
    logic signed [tps_pkg::CoordW-1:0]   seg_head_x;
    logic signed [tps_pkg::CoordW-1:0]   seg_head_y;
    logic signed [tps_pkg::CoordW-1:0]   seg_head_z;

    modport source (output valid, relation, lone_vertex, tail_param, head_param,
                    seg_tail_x, seg_tail_y, seg_tail_z, seg_head_x, seg_head_y,
                    seg_head_z, input ready);
    modport sink (input valid, relation, lone_vertex, tail_param, head_param,
                  seg_tail_x, seg_tail_y, seg_tail_z, seg_head_x, seg_head_y,
                  seg_head_z, output ready);
endinterface

interface tps_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tps_pkg::IdxW-1:0]      index;
    logic [tps_pkg::CoordW-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/triangle_plane_slicer.sv */
// Triangle plane slicer: distance stages, then the 16-stage divider pipeline, then
// rounding, scaling and result stages. Throughput one triangle per cycle when not held.
// The whole pipeline holds while the result register waits to be taken.
// Reset clears valid bits and sets the plane to point 0, normal (0,1,0).
// Depends on tps_pkg, tps_if and tps_div_step.
module triangle_plane_slicer (
    input  logic        clk,
    input  logic        rst_n,
    tps_cfg_if.sink     cfg,
    tps_tri_if.sink     tri_in,
    tps_seg_if.source   seg_out
);

    localparam int Steps = tps_pkg::QuoW;

    logic adv;

    logic signed [tps_pkg::CoordW-1:0] point_reg [3];
    logic signed [tps_pkg::NormW-1:0]  normal_reg [3];

    logic signed [tps_pkg::CoordW-1:0] vin [3][3];

    logic                               v1_reg, v2_reg, v3_reg;
    logic signed [tps_pkg::DiffW-1:0]  diff_reg [3][3];
    logic signed [tps_pkg::ProdW-1:0]  prod_reg [3][3];
    logic signed [tps_pkg::DistW-1:0]  dist_reg [3];
    logic signed [tps_pkg::CoordW-1:0] vert1_reg [3][3];
    logic signed [tps_pkg::CoordW-1:0] vert2_reg [3][3];
    logic signed [tps_pkg::CoordW-1:0] vert3_reg [3][3];

    logic               dv_reg [Steps+1];
    tps_pkg::geo_t      geo_reg [Steps+1];
    tps_pkg::div_t      div1_reg [Steps+1];
    tps_pkg::div_t      div2_reg [Steps+1];
    tps_pkg::div_t      div1_next [Steps+1];
    tps_pkg::div_t      div2_next [Steps+1];
    tps_pkg::geo_t      geo_next;

    logic                         vt_reg;
    tps_pkg::geo_t                geot_reg;
    logic [tps_pkg::ParW-1:0]     t1_reg, t2_reg;

    logic                                 vm_reg;
    tps_pkg::geo_t                        geom_reg;
    logic [tps_pkg::ParW-1:0]             t1m_reg, t2m_reg;
    logic signed [tps_pkg::LerpW-1:0]     m1_reg [3];
    logic signed [tps_pkg::LerpW-1:0]     m2_reg [3];

    logic                                 vo_reg;
    logic [1:0]                           rel_reg, lone_reg;
    logic [tps_pkg::ParW-1:0]             to1_reg, to2_reg;
    logic signed [tps_pkg::CoordW-1:0]    o1_reg [3];
    logic signed [tps_pkg::CoordW-1:0]    o2_reg [3];

    // Advance every stage unless the result register is held
    assign adv          = !vo_reg || seg_out.ready;
    assign tri_in.ready = adv;
    assign cfg.ready    = 1'b1;

    // Plane registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_reg[0]  <= '0;
            point_reg[1]  <= '0;
            point_reg[2]  <= '0;
            normal_reg[0] <= '0;
            normal_reg[1] <= tps_pkg::NormW'(16384);
            normal_reg[2] <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                tps_pkg::CFG_POINT_X:  point_reg[0]  <= cfg.data;
                tps_pkg::CFG_POINT_Y:  point_reg[1]  <= cfg.data;
                tps_pkg::CFG_POINT_Z:  point_reg[2]  <= cfg.data;
                tps_pkg::CFG_NORMAL_X: normal_reg[0] <= cfg.data[tps_pkg::NormW-1:0];
                tps_pkg::CFG_NORMAL_Y: normal_reg[1] <= cfg.data[tps_pkg::NormW-1:0];
                tps_pkg::CFG_NORMAL_Z: normal_reg[2] <= cfg.data[tps_pkg::NormW-1:0];
                default: ;
            endcase
        end
    end

    assign vin[0][0] = tri_in.vertex_a_x;
    assign vin[0][1] = tri_in.vertex_a_y;
    assign vin[0][2] = tri_in.vertex_a_z;
    assign vin[1][0] = tri_in.vertex_b_x;
    assign vin[1][1] = tri_in.vertex_b_y;
    assign vin[1][2] = tri_in.vertex_b_z;
    assign vin[2][0] = tri_in.vertex_c_x;
    assign vin[2][1] = tri_in.vertex_c_y;
    assign vin[2][2] = tri_in.vertex_c_z;

    // Valid bits of the distance stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= tri_in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Offsets from the plane point, products with the normal, distance sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    diff_reg[i][k]  <= tps_pkg::DiffW'(vin[i][k])
                                     - tps_pkg::DiffW'(point_reg[k]);
                    prod_reg[i][k]  <= tps_pkg::ProdW'(diff_reg[i][k])
                                     * tps_pkg::ProdW'(normal_reg[k]);
                    vert1_reg[i][k] <= vin[i][k];
                    vert2_reg[i][k] <= vert1_reg[i][k];
                    vert3_reg[i][k] <= vert2_reg[i][k];
                end
                dist_reg[i] <= tps_pkg::DistW'(prod_reg[i][0])
                             + tps_pkg::DistW'(prod_reg[i][1])
                             + tps_pkg::DistW'(prod_reg[i][2]);
            end
        end
    end

    // Classify the triangle and pick the lone vertex
    always_comb
    begin
        logic       ab, ac;
        logic [1:0] s1, s2, ln;
        ab = tps_pkg::same_side(dist_reg[0], dist_reg[1]);
        ac = tps_pkg::same_side(dist_reg[0], dist_reg[2]);
        s1 = 2'd1;
        s2 = 2'd2;
        ln = 2'd0;
        priority if (ab && ac)
        begin
            geo_next.rel = dist_reg[0][tps_pkg::DistW-1] ? tps_pkg::REL_BELOW
                                                         : tps_pkg::REL_ABOVE;
        end
        else if (ab)
        begin
            geo_next.rel = tps_pkg::REL_CROSS;
            s1 = 2'd0;
            s2 = 2'd1;
            ln = 2'd2;
        end
        else if (ac)
        begin
            geo_next.rel = tps_pkg::REL_CROSS;
            s1 = 2'd2;
            s2 = 2'd0;
            ln = 2'd1;
        end
        else
        begin
            geo_next.rel = tps_pkg::REL_CROSS;
        end
        geo_next.lone = ln;
        for (int k = 0; k < 3; k++)
        begin
            geo_next.s1[k] = vert3_reg[s1][k];
            geo_next.s2[k] = vert3_reg[s2][k];
            geo_next.e1[k] = tps_pkg::DiffW'(vert3_reg[ln][k])
                           - tps_pkg::DiffW'(vert3_reg[s1][k]);
            geo_next.e2[k] = tps_pkg::DiffW'(vert3_reg[ln][k])
                           - tps_pkg::DiffW'(vert3_reg[s2][k]);
        end
        div1_next[0] = tps_pkg::param_prep(dist_reg[s1], dist_reg[ln]);
        div2_next[0] = tps_pkg::param_prep(dist_reg[s2], dist_reg[ln]);
    end

    // Divider pipeline, one quotient bit per stage
    generate
        for (genvar g = 1; g <= Steps; g++)
        begin : g_div
            tps_div_step u_step1 (.cur(div1_reg[g-1]), .nxt(div1_next[g]));
            tps_div_step u_step2 (.cur(div2_reg[g-1]), .nxt(div2_next[g]));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= Steps; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dv_reg[0] <= v3_reg;
            for (int k = 1; k <= Steps; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            geo_reg[0]  <= geo_next;
            div1_reg[0] <= div1_next[0];
            div2_reg[0] <= div2_next[0];
            for (int k = 1; k <= Steps; k++)
            begin
                geo_reg[k]  <= geo_reg[k-1];
                div1_reg[k] <= div1_next[k];
                div2_reg[k] <= div2_next[k];
            end
        end
    end

    // Round the parameters, scale the edges, add the start points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            vt_reg <= dv_reg[Steps];
            vm_reg <= vt_reg;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        logic signed [tps_pkg::LerpW-1:0] r1, r2;
        if (adv)
        begin
            t1_reg   <= tps_pkg::param_final(div1_reg[Steps]);
            t2_reg   <= tps_pkg::param_final(div2_reg[Steps]);
            geot_reg <= geo_reg[Steps];

            t1m_reg  <= t1_reg;
            t2m_reg  <= t2_reg;
            geom_reg <= geot_reg;
            for (int k = 0; k < 3; k++)
            begin
                m1_reg[k] <= $signed({1'b0, t1_reg}) * $signed(geot_reg.e1[k]);
                m2_reg[k] <= $signed({1'b0, t2_reg}) * $signed(geot_reg.e2[k]);
            end

            rel_reg <= geom_reg.rel;
            if (geom_reg.rel == tps_pkg::REL_CROSS)
            begin
                lone_reg <= geom_reg.lone;
                to1_reg  <= t1m_reg;
                to2_reg  <= t2m_reg;
                for (int k = 0; k < 3; k++)
                begin
                    r1 = (m1_reg[k] + tps_pkg::LerpW'(32768)) >>> 16;
                    r2 = (m2_reg[k] + tps_pkg::LerpW'(32768)) >>> 16;
                    o1_reg[k] <= geom_reg.s1[k] + r1[tps_pkg::CoordW-1:0];
                    o2_reg[k] <= geom_reg.s2[k] + r2[tps_pkg::CoordW-1:0];
                end
            end
            else
            begin
                lone_reg <= '0;
                to1_reg  <= '0;
                to2_reg  <= '0;
                for (int k = 0; k < 3; k++)
                begin
                    o1_reg[k] <= '0;
                    o2_reg[k] <= '0;
                end
            end
        end
    end

    // Drive the result channel
    assign seg_out.valid       = vo_reg;
    assign seg_out.relation    = rel_reg;
    assign seg_out.lone_vertex = lone_reg;
    assign seg_out.tail_param  = to1_reg;
    assign seg_out.head_param  = to2_reg;
    assign seg_out.seg_tail_x  = o1_reg[0];
    assign seg_out.seg_tail_y  = o1_reg[1];
    assign seg_out.seg_tail_z  = o1_reg[2];
    assign seg_out.seg_head_x  = o2_reg[0];
    assign seg_out.seg_head_y  = o2_reg[1];
    assign seg_out.seg_head_z  = o2_reg[2];

endmodule

/* src/tps_div_step.sv */
// One restoring division step: shift the remainder, compare, subtract.
// Depends on tps_pkg for the divider record.
module tps_div_step (
    input  tps_pkg::div_t cur,
    output tps_pkg::div_t nxt
);

    logic [tps_pkg::DivW:0] shifted;
    logic                   ge;

    // Produce one quotient bit
    always_comb
    begin
        shifted = {cur.rem, 1'b0};
        ge      = shifted >= {1'b0, cur.den};
        nxt.sat = cur.sat;
        nxt.den = cur.den;
        nxt.rem = ge ? tps_pkg::DivW'(shifted - {1'b0, cur.den})
                     : tps_pkg::DivW'(shifted);
        nxt.quo = {cur.quo[tps_pkg::QuoW-2:0], ge};
    end

endmodule

/* sim/tb.sv */
// Self-checking bench for the triangle plane slicer: streams triangles against
// several plane settings and checks every segment against a local predictor.
// Depends on tps_pkg, tps_if and the slicer RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [0:2][0:2][31:0] v;   // [vertex][axis], vertex a and axis x first
    } tri_t;

    typedef struct packed {
        logic [1:0]  relation;
        logic [1:0]  lone;
        logic [16:0] tp;
        logic [16:0] hp;
        logic [2:0][31:0] tail;
        logic [2:0][31:0] head;
    } seg_t;

    logic clk;
    logic rst_n;

    tps_cfg_if cfg();
    tps_tri_if tri_in();
    tps_seg_if seg_out();

    triangle_plane_slicer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .tri_in  (tri_in),
        .seg_out (seg_out)
    );

    // Plane held by the predictor
    logic signed [31:0] plane_pt [3];
    logic signed [15:0] plane_nrm [3];

    tri_t pending_tris [$];
    seg_t expected_segs [$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   errors;
    int   triangles_sent;
    int   segments_seen;
    int   crossings_seen;
    longint cycles;

    function automatic logic sides_agree(longint d1, longint d2);
        return !((d1 > 0 && d2 < 0) || (d1 < 0 && d2 > 0));
    endfunction

    // Rounded ratio -ds/(dl-ds), clamped to [0,1] in Q1.16
    function automatic logic [16:0] crossing_param(longint ds, longint dl);
        longint a, b, r;
        logic [15:0] q;
        a = -ds;
        b = dl - ds;
        if (a == 0 || b == 0 || ((a < 0) != (b < 0)))
            return 17'd0;
        if (a < 0)
        begin
            a = -a;
            b = -b;
        end
        if (a >= b)
            return 17'd65536;
        r = a;
        q = '0;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= b)
            begin
                r = r - b;
                q[0] = 1'b1;
            end
        end
        return {1'b0, q} + ((2 * r >= b) ? 17'd1 : 17'd0);
    endfunction

    // Point on S towards L at parameter t, rounded halves up
    function automatic logic [31:0] slide(longint s, longint l, logic [16:0] t);
        longint x;
        x = longint'(t) * (l - s) + 32768;
        return 32'(s + (x >>> 16));
    endfunction

    function automatic seg_t slice(tri_t t);
        seg_t r;
        longint d [3];
        int s1, s2, ln;
        r = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = 0;
            for (int k = 0; k < 3; k++)
                d[i] += (longint'($signed(t.v[i][k])) - longint'(plane_pt[k]))
                        * longint'(plane_nrm[k]);
        end
        if (sides_agree(d[0], d[1]) && sides_agree(d[0], d[2]))
        begin
            r.relation = (d[0] >= 0) ? tps_pkg::REL_ABOVE : tps_pkg::REL_BELOW;
            return r;
        end
        if (sides_agree(d[0], d[1]))
        begin
            s1 = 0; s2 = 1; ln = 2;
        end
        else if (sides_agree(d[0], d[2]))
        begin
            s1 = 2; s2 = 0; ln = 1;
        end
        else
        begin
            s1 = 1; s2 = 2; ln = 0;
        end
        r.relation = tps_pkg::REL_CROSS;
        r.lone = 2'(ln);
        r.tp = crossing_param(d[s1], d[ln]);
        r.hp = crossing_param(d[s2], d[ln]);
        for (int k = 0; k < 3; k++)
        begin
            r.tail[k] = slide($signed(t.v[s1][k]), $signed(t.v[ln][k]), r.tp);
            r.head[k] = slide($signed(t.v[s2][k]), $signed(t.v[ln][k]), r.hp);
        end
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Driver: offer queued triangles, idling at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tri_in.valid <= 1'b0;
        else
        begin
            if (tri_in.valid && tri_in.ready)
            begin
                expected_segs.insert(expected_segs.size(), slice({tri_in.vertex_a_x,
                    tri_in.vertex_a_y, tri_in.vertex_a_z, tri_in.vertex_b_x,
                    tri_in.vertex_b_y, tri_in.vertex_b_z, tri_in.vertex_c_x,
                    tri_in.vertex_c_y, tri_in.vertex_c_z} ));
                triangles_sent++;
            end
            if ((!tri_in.valid || tri_in.ready) && pending_tris.size() > 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                tri_t t;
                t = pending_tris.pop_front();
                tri_in.valid <= 1'b1;
                {tri_in.vertex_a_x, tri_in.vertex_a_y, tri_in.vertex_a_z,
                 tri_in.vertex_b_x, tri_in.vertex_b_y, tri_in.vertex_b_z,
                 tri_in.vertex_c_x, tri_in.vertex_c_y, tri_in.vertex_c_z} <= t;
            end
            else if (tri_in.ready)
                tri_in.valid <= 1'b0;
        end
    end

    // Monitor: compare each segment transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_out.ready <= 1'b0;
        else
        begin
            if (seg_out.valid && seg_out.ready)
            begin
                seg_t got, want;
                got = {seg_out.relation, seg_out.lone_vertex, seg_out.tail_param,
                       seg_out.head_param, seg_out.seg_tail_z, seg_out.seg_tail_y,
                       seg_out.seg_tail_x, seg_out.seg_head_z, seg_out.seg_head_y,
                       seg_out.seg_head_x};
                segments_seen++;
                if (expected_segs.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected segment %h", $time, got);
                end
                else
                begin
                    want = expected_segs.pop_front();
                    // Predictor stores axes in index order; reverse for packed compare
                    want = {want.relation, want.lone, want.tp, want.hp,
                            want.tail[2], want.tail[1], want.tail[0],
                            want.head[2], want.head[1], want.head[0]};
                    if (want.relation == tps_pkg::REL_CROSS)
                        crossings_seen++;
                    if (got.relation !== want.relation || got.lone !== want.lone
                        || got.tp !== want.tp || got.hp !== want.hp)
                    begin
                        errors++;
                        $display("%0t: rel/lone/t1/t2 expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 $time, want.relation, want.lone, want.tp, want.hp,
                                 got.relation, got.lone, got.tp, got.hp);
                    end
                    if (got.tail !== want.tail || got.head !== want.head)
                    begin
                        errors++;
                        $display("%0t: endpoints expected %h %h got %h %h",
                                 $time, want.tail, want.head, got.tail, got.head);
                    end
                end
            end
            seg_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_tris.size() > 0 || tri_in.valid || expected_segs.size() > 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // Write one register, then leave the channel idle before returning
    task automatic write_reg(logic [tps_pkg::IdxW-1:0] idx, logic [31:0] val);
        cfg.index <= idx;
        cfg.data  <= val;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx <= tps_pkg::CFG_POINT_Z)
            plane_pt[idx] = val;
        else if (idx <= tps_pkg::CFG_NORMAL_Z)
            plane_nrm[idx - tps_pkg::CFG_NORMAL_X] = val[15:0];
        @(posedge clk);
    endtask

    task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
        write_reg(tps_pkg::CFG_POINT_X, px);
        write_reg(tps_pkg::CFG_POINT_Y, py);
        write_reg(tps_pkg::CFG_POINT_Z, pz);
        write_reg(tps_pkg::CFG_NORMAL_X, {16'h0, nx});
        write_reg(tps_pkg::CFG_NORMAL_Y, {16'h0, ny});
        write_reg(tps_pkg::CFG_NORMAL_Z, {16'h0, nz});
    endtask

    function automatic logic [31:0] coord(int span);
        if (span == 0)
            return $urandom();
        return 32'($signed($urandom_range(2 * span)) - span);
    endfunction

    function automatic logic [15:0] rnd_normal();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic queue_tri(logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        pending_tris.insert(pending_tris.size(), {ax, ay, az, bx, by, bz, cx, cy, cz});
    endtask

    // Random triangles, mostly straddling the plane
    task automatic queue_random(int count);
        for (int n = 0; n < count; n++)
        begin
            int span;
            tri_t t;
            span = ($urandom_range(9) == 0) ? 0 : (1 << $urandom_range(8, 22));
            for (int i = 0; i < 3; i++)
                for (int k = 0; k < 3; k++)
                    t.v[i][k] = 32'(plane_pt[k]) + coord(span);
            if ($urandom_range(15) == 0)
                t.v[$urandom_range(2)] = {plane_pt[0], plane_pt[1], plane_pt[2]};
            if ($urandom_range(15) == 0)
                t.v[$urandom_range(2)] = t.v[$urandom_range(2)];
            pending_tris.insert(pending_tris.size(), t);
        end
    endtask

    initial
    begin
        logic [31:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        tri_in.valid = 1'b0;
        {tri_in.vertex_a_x, tri_in.vertex_a_y, tri_in.vertex_a_z,
         tri_in.vertex_b_x, tri_in.vertex_b_y, tri_in.vertex_b_z,
         tri_in.vertex_c_x, tri_in.vertex_c_y, tri_in.vertex_c_z} = '0;
        seg_out.ready = 1'b0;
        plane_pt = '{0, 0, 0};
        plane_nrm = '{0, 16384, 0};
        errors = 0;
        triangles_sent = 0;
        segments_seen = 0;
        crossings_seen = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset plane y = 0, normal +y
        queue_tri(0, 65536, 0, 0, 131072, 0, 65536, 65536, 0);            // above
        queue_tri(0, -65536, 0, 0, -5, 0, 7, -1, 0);                      // below
        queue_tri(0, 0, 0, 0, 0, 0, 0, 0, 0);                             // all on plane
        queue_tri(0, 0, 0, 0, 65536, 0, 0, -65536, 0);                    // a on plane, b c apart
        queue_tri(0, 65536, 0, 65536, 65536, 0, 0, -65536, 65536);        // lone c
        queue_tri(0, 65536, 0, 65536, -65536, 0, 0, 65536, 65536);        // lone b
        queue_tri(0, -65536, 0, 65536, 65536, 0, 0, 65536, 65536);        // lone a
        queue_tri(mx, mx, mx, mn, mn, mn, mx, mn, mx);                    // extremes
        queue_tri(mn, mn, mn, mx, mx, mx, mn, mx, mn);
        queue_tri(mn, 1, mx, mx, -1, mn, 0, 3, 0);                        // rounding halves
        queue_tri(5, 1, 9, 1, -2, 3, -4, 2, 8);
        wait_drained();

        // Directed: extreme plane, odd normal
        set_plane(mx, mn, mx, 16'h8000, 16'h4000, 16'hc000);
        queue_tri(mx, mx, mx, mn, mn, mn, 0, 0, 0);
        queue_tri(mn, mx, mn, mx, mn, mx, mx, mx, mn);
        queue_tri(mx, mn, mx, mx, mn, mx, mx, mn, mx);
        queue_tri(32'hffffffff, 0, 1, 1, 0, 32'hffffffff, mn, mx, 0);
        wait_drained();
        set_plane(0, 0, 0, 16'h4000, 16'hc000, 16'h4000);
        write_reg(3'd7, 32'hdeadbeef);   // unused index, ignored
        queue_random(10);
        wait_drained();

        // Random phases over several idling patterns and planes
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            set_plane(coord(ph < 4 ? (1 << 20) : 0), coord(1 << 20), coord(1 << 20),
                      rnd_normal(), rnd_normal(), rnd_normal());
            queue_random(75);
            // Hold off until the block has emptied, then resume
            while (pending_tris.size() > 0 || tri_in.valid)
                @(posedge clk);
            wait_drained();
            queue_random(75);
            wait_drained();
        end

        $display("Sent %0d triangles over 11 plane settings; %0d segments, %0d crossings.",
                 triangles_sent, segments_seen, crossings_seen);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
